>>> rtl/lim_pkg.sv
// Shared types and constants for the loop interval monitor.
// Used by the front classifier, the command queue, the back end and the top level.
// No dependencies.
package lim_pkg;

  localparam int TIME_WIDTH  = 48;
  localparam int COUNT_WIDTH = 32;
  localparam int SUM_WIDTH   = 64;
  localparam int FIFO_DEPTH  = 2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_EDGE,
    CMD_REPORT
  } lim_cmd_e;

  typedef struct packed {
    lim_cmd_e              cmd;
    logic [TIME_WIDTH-1:0] interval;
  } lim_cmd_t;

endpackage

>>> rtl/lim_front.sv
// Front part of the loop interval monitor: accepts transactions, tracks the toggle
// level and the last edge time, and turns each item into a command for the back end.
// Depends on lim_pkg.
module lim_front import lim_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic                  toggle_level_i,
  input  logic [TIME_WIDTH-1:0] now_us_i,
  output logic                  push_o,
  output lim_cmd_t              cmd_o,
  input  logic                  queue_ready_i
);

  logic                  seen_level_q, seen_level_d;
  logic                  have_prev_q, have_prev_d;
  logic [TIME_WIDTH-1:0] prev_time_q, prev_time_d;
  logic                  accept;
  logic                  change;

  assign in_ready_o = queue_ready_i;
  assign accept     = in_valid_i && queue_ready_i;
  assign push_o     = accept;
  assign change     = (kind_i == KIND_SAMPLE) && (toggle_level_i != seen_level_q);

  always_comb begin
    seen_level_d  = seen_level_q;
    have_prev_d   = have_prev_q;
    prev_time_d   = prev_time_q;
    cmd_o.interval = now_us_i - prev_time_q;
    if (kind_i == KIND_REPORT) begin
      cmd_o.cmd = CMD_REPORT;
    end else if (change && have_prev_q) begin
      cmd_o.cmd = CMD_EDGE;
    end else begin
      cmd_o.cmd = CMD_NONE;
    end
    if (accept && change) begin
      seen_level_d = toggle_level_i;
      have_prev_d  = 1'b1;
      prev_time_d  = now_us_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_level_q <= 1'b0;
      have_prev_q  <= 1'b0;
      prev_time_q  <= '0;
    end else begin
      seen_level_q <= seen_level_d;
      have_prev_q  <= have_prev_d;
      prev_time_q  <= prev_time_d;
    end
  end

endmodule

>>> rtl/lim_queue.sv
// Short command queue between the front classifier and the back end.
// Holds FIFO_DEPTH commands in registers. Depends on lim_pkg.
module lim_queue import lim_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lim_cmd_t data_i,
  output logic     ready_o,
  output logic     valid_o,
  input  logic     pop_i,
  output lim_cmd_t data_o
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  lim_cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/lim_back.sv
// Back part of the loop interval monitor: executes queued commands, keeps the
// interval statistics, runs the bit-serial window average divide and holds the result.
// Depends on lim_pkg.
module lim_back import lim_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  lim_cmd_t               cmd_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   edge_seen_o,
  output logic [TIME_WIDTH-1:0]  interval_us_o,
  output logic [TIME_WIDTH-1:0]  max_interval_us_o,
  output logic [TIME_WIDTH-1:0]  average_us_o,
  output logic [COUNT_WIDTH-1:0] total_intervals_o
);

  localparam int DIV_STEPS = SUM_WIDTH;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } state_e;

  state_e                 state_q;
  logic                   out_valid_q;
  logic                   edge_q;
  logic [TIME_WIDTH-1:0]  last_q;
  logic [TIME_WIDTH-1:0]  max_q;
  logic [TIME_WIDTH-1:0]  avg_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [SUM_WIDTH-1:0]   wsum_q;
  logic [COUNT_WIDTH-1:0] wcount_q;
  logic [SUM_WIDTH-1:0]   quo_q;
  logic [COUNT_WIDTH:0]   rem_q;
  logic [COUNT_WIDTH-1:0] divisor_q;
  logic [STEP_W-1:0]      step_q;

  logic [SUM_WIDTH:0]     sum_ext;
  logic [SUM_WIDTH-1:0]   sum_sat;
  logic [COUNT_WIDTH:0]   rem_shift;
  logic [COUNT_WIDTH:0]   rem_next;
  logic [SUM_WIDTH-1:0]   quo_next;
  logic                   fits;
  logic [TIME_WIDTH-1:0]  quo_sat;

  assign pop_o = (state_q == ST_RUN) && cmd_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    sum_ext   = {1'b0, wsum_q} + (SUM_WIDTH + 1)'(cmd_i.interval);
    sum_sat   = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
    rem_shift = {rem_q[COUNT_WIDTH-1:0], quo_q[SUM_WIDTH-1]};
    fits      = rem_shift >= {1'b0, divisor_q};
    rem_next  = fits ? rem_shift - {1'b0, divisor_q} : rem_shift;
    quo_next  = {quo_q[SUM_WIDTH-2:0], fits};
    quo_sat   = (quo_next[SUM_WIDTH-1:TIME_WIDTH] != '0) ? '1
                                                           : quo_next[TIME_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
      edge_q      <= 1'b0;
      last_q      <= '0;
      max_q       <= '0;
      avg_q       <= '0;
      count_q     <= '0;
      wsum_q      <= '0;
      wcount_q    <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      divisor_q   <= '0;
      step_q      <= '0;
    end else begin
      case (state_q)
        ST_RUN: begin
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (pop_o) begin
            edge_q <= 1'b0;
            case (cmd_i.cmd)
              CMD_EDGE: begin
                edge_q      <= 1'b1;
                out_valid_q <= 1'b1;
                last_q      <= cmd_i.interval;
                if (cmd_i.interval > max_q) begin
                  max_q <= cmd_i.interval;
                end
                count_q <= count_q + 1'b1;
                wsum_q  <= sum_sat;
                if (wcount_q != '1) begin
                  wcount_q <= wcount_q + 1'b1;
                end
              end
              CMD_REPORT: begin
                wsum_q   <= '0;
                wcount_q <= '0;
                if (wcount_q == '0) begin
                  out_valid_q <= 1'b1;
                end else begin
                  out_valid_q <= 1'b0;
                  quo_q       <= wsum_q;
                  rem_q       <= '0;
                  divisor_q   <= wcount_q;
                  step_q      <= '0;
                  state_q     <= ST_DIV;
                end
              end
              default: begin
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        ST_DIV: begin
          quo_q  <= quo_next;
          rem_q  <= rem_next;
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            avg_q       <= quo_sat;
            out_valid_q <= 1'b1;
            step_q      <= '0;
            state_q     <= ST_RUN;
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign edge_seen_o       = edge_q;
  assign interval_us_o     = last_q;
  assign max_interval_us_o = max_q;
  assign average_us_o      = avg_q;
  assign total_intervals_o = count_q;

  a_div_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !out_valid_q)
    else $error("result shown while the divide is running");

  a_max_bounds_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q >= last_q)
    else $error("maximum interval below last interval");

  a_empty_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wcount_q == '0) |-> (wsum_q == '0))
    else $error("window sum nonzero with empty window");

  a_edge_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.cmd == CMD_EDGE) |=> (count_q == $past(count_q) + 1'b1))
    else $error("interval count did not advance on an edge");

  a_step_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q == '0))
    else $error("divide step counter active outside the divide");

endmodule

>>> rtl/loop_interval_monitor.sv
// Top level of the loop interval monitor: front classifier, command queue, back end.
// Depends on lim_pkg, lim_front, lim_queue and lim_back.
//
// Channel   Handshake                 Payload
// in        in_valid_i / in_ready_o   kind_i, toggle_level_i, now_us_i
// out       out_valid_o / out_ready_i edge_seen_o, interval_us_o, max_interval_us_o,
//                                     average_us_o, total_intervals_o
//
// Samples and reports with an empty window need no divide in the back end,
// so one transaction per cycle is sustained while the output is taken.
// A report with a nonempty window runs a bit-serial 64 by 32 bit divide.
// The two-entry queue accepts input while the back end divides or the output stalls, until full.
// Reset clears all statistics at once; no clearing pass is needed.
module loop_interval_monitor import lim_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   kind_i,
  input  logic                   toggle_level_i,
  input  logic [TIME_WIDTH-1:0]  now_us_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   edge_seen_o,
  output logic [TIME_WIDTH-1:0]  interval_us_o,
  output logic [TIME_WIDTH-1:0]  max_interval_us_o,
  output logic [TIME_WIDTH-1:0]  average_us_o,
  output logic [COUNT_WIDTH-1:0] total_intervals_o
);

  logic     push;
  lim_cmd_t push_cmd;
  logic     queue_ready;
  logic     queue_valid;
  logic     pop;
  lim_cmd_t pop_cmd;

  lim_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .toggle_level_i(toggle_level_i),
    .now_us_i      (now_us_i),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .queue_ready_i (queue_ready)
  );

  lim_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .ready_o(queue_ready),
    .valid_o(queue_valid),
    .pop_i  (pop),
    .data_o (pop_cmd)
  );

  lim_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (queue_valid),
    .cmd_i            (pop_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .edge_seen_o      (edge_seen_o),
    .interval_us_o    (interval_us_o),
    .max_interval_us_o(max_interval_us_o),
    .average_us_o     (average_us_o),
    .total_intervals_o(total_intervals_o)
  );

endmodule
